// ===== hdl/cir_pkg.sv =====
package cir_pkg;

  localparam int RingDepth = 12;
  localparam int PtrW      = $clog2(RingDepth);
  localparam int CntW      = $clog2(RingDepth + 1);
  localparam int IdxW      = $clog2(2 * RingDepth + 4);

  localparam int SampleW   = 16;
  localparam int RateW     = 24;
  localparam int RateFracW = 20;
  localparam int PhaseW    = 25;
  localparam int FracW     = 15;
  localparam int DropW     = PhaseW - FracW;
  localparam int StepW     = RateW + 1;
  localparam int StepShift = RateFracW - FracW;
  localparam int HalfLsb   = 16;

  localparam int NumTaps   = 4;
  localparam int TapW      = $clog2(NumTaps);
  localparam int RdCntW    = $clog2(NumTaps + 1);
  localparam int MinFill   = 4;
  localparam int BusyFill  = 8;

  // datapath widths: accumulator, second multiplier operand, product
  localparam int AccW      = 21;
  localparam int MulBW     = 17;
  localparam int ProdW     = AccW + MulBW;
  localparam int HalfOne   = 32768;

  // truncating divide of (65536 - p) by six through a reciprocal
  localparam int Div6InW   = 17;
  localparam int Div6MulW  = 16;
  localparam int Div6Shift = 18;
  localparam int RecipW    = Div6InW + Div6MulW;
  localparam int Div6Num   = 65536;
  localparam logic [Div6MulW-1:0] Div6Mul = 16'd43691;

  localparam logic signed [AccW-1:0]    AccSatHi  = AccW'(32767);
  localparam logic signed [AccW-1:0]    AccSatLo  = AccW'(-32768);
  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  typedef enum logic [1:0] {
    KindPush  = 2'd0,
    KindPop   = 2'd1,
    KindClear = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StDiff,
    StMul,
    StOut
  } state_e;

  typedef enum logic [1:0] {
    MulCubic,
    MulQuad,
    MulLin
  } mul_sel_e;

  typedef struct packed {
    logic            cap_en;
    logic [TapW-1:0] cap_idx;
    logic            load_diff;
    logic            mul_en;
    mul_sel_e        mul_sel;
  } cir_dp_ctrl_t;

endpackage

// ===== hdl/cir_in_if.sv =====
interface cir_in_if import cir_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic signed [SampleW-1:0] sample_in;
  logic [RateW-1:0]          rate_fx;

  modport source (output valid, kind, sample_in, rate_fx, input ready);
  modport sink (input valid, kind, sample_in, rate_fx, output ready);
endinterface

// ===== hdl/cir_out_if.sv =====
interface cir_out_if import cir_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_out;
  logic                      starved;

  modport source (output valid, sample_out, starved, input ready);
  modport sink (input valid, sample_out, starved, output ready);
endinterface

// ===== hdl/cubic_interp_resampler_core.sv =====
// Cubic Newton-form audio resampler over a twelve-sample ring. Push and clear
// items complete as they are accepted. A pop that finds fewer than four samples
// after dropping the consumed ones goes straight to the output step and returns
// zero with starved set. A full pop steps through accepting and dropping,
// fetching the four oldest samples through the ring memory's single registered
// read port, forming the differences, three passes through the one shared
// multiplier, and saturating into the result register.
// The result register lets pushes be accepted while a result waits; a pop
// holds at its last step until the previous result has been taken.
module cubic_interp_resampler_core import cir_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  cir_in_if.sink    in_i,
  cir_out_if.source out_o
);

  state_e                    state_q, state_d;
  logic [PtrW-1:0]           wptr_q;
  logic [CntW-1:0]           fill_q;
  logic [PhaseW-1:0]         phase_q;
  logic [RateW-1:0]          rate_q;
  logic [RdCntW-1:0]         rd_cnt_q;
  mul_sel_e                  mul_q;
  logic                      starved_q;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_sample_q;
  logic                      out_starved_q;

  logic                      in_ready;
  logic                      in_fire;
  logic                      is_push, is_pop, is_clear;
  logic                      out_free;
  logic                      out_load;
  logic                      ring_we;
  logic [DropW-1:0]          drop;
  logic [DropW-1:0]          fill_ext;
  logic [CntW-1:0]           fill_drop;
  logic                      pop_starve;
  logic [IdxW-1:0]           base_sum, base, idx_sum, idx;
  logic [PtrW-1:0]           raddr;
  logic signed [SampleW-1:0] rdata;
  logic signed [AccW-1:0]    acc;
  logic signed [SampleW-1:0] sat_sample;
  logic [StepW-1:0]          step;
  cir_dp_ctrl_t              dp_ctrl;

  assign in_fire  = in_i.valid && in_ready;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    is_push  = 1'b0;
    is_pop   = 1'b0;
    is_clear = 1'b0;
    unique case (in_i.kind)
      KindPush:  is_push  = 1'b1;
      KindPop:   is_pop   = 1'b1;
      KindClear: is_clear = 1'b1;
      default: ;
    endcase
  end

  assign drop       = phase_q[PhaseW-1:FracW];
  assign fill_ext   = DropW'(fill_q);
  assign fill_drop  = (drop > fill_ext) ? '0 : CntW'(fill_ext - drop);
  assign pop_starve = fill_drop < CntW'(MinFill);

  // oldest held sample sits at write pointer minus fill, modulo the depth
  assign base_sum = IdxW'(wptr_q) + IdxW'(RingDepth) - IdxW'(fill_q);
  assign base     = (base_sum >= IdxW'(RingDepth)) ? base_sum - IdxW'(RingDepth) : base_sum;
  assign idx_sum  = base + IdxW'(rd_cnt_q);
  assign idx      = (idx_sum >= IdxW'(RingDepth)) ? idx_sum - IdxW'(RingDepth) : idx_sum;
  assign raddr    = PtrW'(idx);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire && is_pop) begin
          state_d = pop_starve ? StOut : StRead;
        end
      end
      StRead: begin
        if (rd_cnt_q == RdCntW'(NumTaps)) begin
          state_d = StDiff;
        end
      end
      StDiff: state_d = StMul;
      StMul: begin
        if (mul_q == MulLin) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready          = (state_q == StIdle);
    ring_we           = in_fire && is_push;
    out_load          = (state_q == StOut) && out_free;
    dp_ctrl.cap_en    = (state_q == StRead) && (rd_cnt_q != '0);
    dp_ctrl.cap_idx   = TapW'(rd_cnt_q - 1'b1);
    dp_ctrl.load_diff = (state_q == StDiff);
    dp_ctrl.mul_en    = (state_q == StMul);
    dp_ctrl.mul_sel   = mul_q;
  end

  assign in_i.ready = in_ready;

  cir_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wptr_q),
    .wdata_i (in_i.sample_in),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cir_datapath u_datapath (
    .clk_i        (clk_i),
    .ctrl_i       (dp_ctrl),
    .rdata_i      (rdata),
    .phase_frac_i (phase_q[FracW-1:0]),
    .acc_o        (acc)
  );

  // half a phase lsb extra when the ring holds more than eight samples, to drain it
  assign step = {1'b0, rate_q} + ((fill_q > CntW'(BusyFill)) ? StepW'(HalfLsb) : '0);

  always_comb begin
    if (acc > AccSatHi) begin
      sat_sample = SampleMax;
    end else if (acc < AccSatLo) begin
      sat_sample = SampleMin;
    end else begin
      sat_sample = acc[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wptr_q      <= '0;
      fill_q      <= '0;
      phase_q     <= '0;
      rd_cnt_q    <= '0;
      mul_q       <= MulCubic;
      starved_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ring_we) begin
        wptr_q <= (wptr_q == PtrW'(RingDepth - 1)) ? '0 : wptr_q + 1'b1;
        if (fill_q < CntW'(RingDepth)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (in_fire && is_clear) begin
        wptr_q  <= '0;
        fill_q  <= '0;
        phase_q <= '0;
      end
      if (in_fire && is_pop) begin
        phase_q   <= PhaseW'(phase_q[FracW-1:0]);
        fill_q    <= fill_drop;
        starved_q <= pop_starve;
        rd_cnt_q  <= '0;
      end
      if (state_q == StRead) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
      if (state_q == StDiff) begin
        mul_q <= MulCubic;
      end
      if (state_q == StMul) begin
        case (mul_q)
          MulCubic: mul_q <= MulQuad;
          MulQuad:  mul_q <= MulLin;
          default:  mul_q <= MulCubic;
        endcase
      end
      if (out_load && !starved_q) begin
        phase_q <= phase_q + PhaseW'(step[StepW-1:StepShift]);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_pop) begin
      rate_q <= in_i.rate_fx;
    end
    if (out_load) begin
      out_sample_q  <= starved_q ? '0 : sat_sample;
      out_starved_q <= starved_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.starved    = out_starved_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(RingDepth) && wptr_q < PtrW'(RingDepth))
    else $error("ring fill or write pointer out of range");

  a_phase_masked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> phase_q[PhaseW-1:FracW] == '0)
    else $error("phase integer part not dropped during pop");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_sample_q))
    else $error("waiting result overwritten");

  a_starved_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_starved_q |-> out_sample_q == '0)
    else $error("starved result not zero");

  a_read_before_calc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiff |-> $past(state_q) == StRead && fill_q >= CntW'(MinFill))
    else $error("differences formed without a full sample fetch");

endmodule

// ===== hdl/cir_ring.sv =====
module cir_ring import cir_pkg::*; (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [PtrW-1:0]           waddr_i,
  input  logic signed [SampleW-1:0] wdata_i,
  input  logic [PtrW-1:0]           raddr_i,
  output logic signed [SampleW-1:0] rdata_o
);

  logic signed [SampleW-1:0] mem [RingDepth];
  logic signed [SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cir_datapath.sv =====
module cir_datapath import cir_pkg::*; (
  input  logic                      clk_i,
  input  cir_dp_ctrl_t              ctrl_i,
  input  logic signed [SampleW-1:0] rdata_i,
  input  logic [FracW-1:0]          phase_frac_i,
  output logic signed [AccW-1:0]    acc_o
);

  logic signed [SampleW-1:0] s_q [NumTaps];
  logic signed [AccW-1:0]    t0, t1, t2, t3;
  logic signed [AccW-1:0]    d3, d2, d1;
  logic signed [AccW-1:0]    d3_q, d2_q, d1_q;
  logic signed [MulBW-1:0]   q_q;
  logic signed [MulBW-1:0]   q_pos;
  logic [Div6InW-1:0]        div_n;
  logic [RecipW-1:0]         recip_q;
  logic signed [MulBW-1:0]   p_s;
  logic signed [MulBW-1:0]   h;
  logic signed [AccW-1:0]    mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [AccW-1:0]    addend;
  logic signed [ProdW-1:0]   prod;
  logic signed [AccW-1:0]    acc_d;
  logic signed [AccW-1:0]    acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_en) begin
      s_q[ctrl_i.cap_idx] <= rdata_i;
    end
  end

  assign t0 = AccW'(s_q[0]);
  assign t1 = AccW'(s_q[1]);
  assign t2 = AccW'(s_q[2]);
  assign t3 = AccW'(s_q[3]);

  assign d3 = t3 - ((t2 <<< 1) + t2) + ((t1 <<< 1) + t1) - t0;
  assign d2 = t2 - (t1 <<< 1) + t0;
  assign d1 = t1 - t0;

  // (p - 65536) / 6 truncates toward zero, so divide the magnitude and negate
  assign div_n = Div6InW'(Div6Num) - Div6InW'(phase_frac_i);

  always_ff @(posedge clk_i) begin
    recip_q <= div_n * Div6Mul;
  end

  assign q_pos = $signed(MulBW'(recip_q[RecipW-1:Div6Shift]));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_diff) begin
      d3_q <= d3;
      d2_q <= d2;
      d1_q <= d1;
      q_q  <= -q_pos;
    end
  end

  // floor((p - 32768) / 2)
  assign p_s = $signed({2'b00, phase_frac_i});
  assign h   = (p_s - MulBW'(HalfOne)) >>> 1;

  always_comb begin
    case (ctrl_i.mul_sel)
      MulCubic: begin
        mul_a  = d3_q;
        mul_b  = q_q;
        addend = d2_q;
      end
      MulQuad: begin
        mul_a  = acc_q;
        mul_b  = h;
        addend = d1_q;
      end
      default: begin
        mul_a  = acc_q;
        mul_b  = p_s;
        addend = t0;
      end
    endcase
  end

  assign prod  = ProdW'(mul_a) * ProdW'(mul_b);
  assign acc_d = AccW'(prod >>> FracW) + addend;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
